@@ rtl/tds_pkg.sv @@
package tds_pkg;

  localparam int MAX_ROWS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int RC_W     = 7;
  localparam int ADDR_W   = 3;

  localparam logic [ADDR_W-1:0] REG_ROW_COUNT = '0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL1,
    S_DEN,
    S_NO,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_BWT,
    S_BMUL,
    S_BADD,
    S_EWT,
    S_EOUT
  } state_t;

  typedef struct packed {
    logic               done;
    logic               err;
    logic signed [31:0] quo;
  } div_res_t;

  typedef struct packed {
    logic               err;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t s;
    if (v > 64'sh7FFF_FFFF) begin
      s.err = 1'b1;
      s.val = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      s.err = 1'b1;
      s.val = 32'sh8000_0000;
    end else begin
      s.err = 1'b0;
      s.val = v[31:0];
    end
    return s;
  endfunction

endpackage

@@ rtl/tds_div.sv @@
module tds_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output tds_pkg::div_res_t  res
);
  import tds_pkg::*;

  logic        busy;
  logic        fin;
  logic [5:0]  cnt;
  logic [47:0] nsh;
  logic [47:0] q;
  logic [32:0] rem;
  logic [31:0] dm;
  logic        neg;
  logic [32:0] remsh;
  logic        ge;

  assign remsh = {rem[31:0], nsh[47]};
  assign ge    = remsh >= {1'b0, dm};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      fin      <= 1'b0;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        if (den == 32'sd0) begin
          res.done <= 1'b1;
          res.err  <= 1'b1;
          res.quo  <= num[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
          nsh  <= {(num[31] ? (~num + 32'd1) : num), 16'd0};
          dm   <= den[31] ? (~den + 32'd1) : den;
          rem  <= '0;
          q    <= '0;
          neg  <= num[31] ^ den[31];
        end
      end else if (busy) begin
        rem <= ge ? (remsh - {1'b0, dm}) : remsh;
        q   <= {q[46:0], ge};
        nsh <= {nsh[46:0], 1'b0};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin      <= 1'b0;
        res.done <= 1'b1;
        if (!neg) begin
          res.err <= q > 48'h7FFF_FFFF;
          res.quo <= (q > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
        end else begin
          res.err <= q > 48'h8000_0000;
          res.quo <= (q > 48'h8000_0000) ? 32'sh8000_0000 : (~q[31:0] + 32'd1);
        end
      end
    end
  end

endmodule

@@ rtl/tridiagonal_system_solver.sv @@
// Tridiagonal solver, Thomas algorithm, signed Q16.16.
// Input channel: one matrix row per transaction (sub_diag, main_diag,
// super_diag, rhs), lowest row first. in_stall is high from an accepted row
// until its sweep is done, and on the last row until its results are out.
// Each row goes through two multiplies on the shared 32x32 multiplier and
// two divides on the shared radix-2 divider (48 steps each), which set the
// row rate.
// After the last row (row_count - 1) back-substitution runs through
// BWT, BMUL and BADD per unknown, then results stream out from the highest
// index down to 0, one per EWT/EOUT pass while out_stall is low. last_of_run
// marks index 0; arith_error is set on every result of a solve that saw a
// zero pivot or a saturation. While out_stall is high the result holds.
// row_count is written over the APB port at address 0 from pwdata[6:0]
// (reset 64; values below 2 act as 2, above 64 as 64).
// Reset clears the sequencer, row counter and error flag; the ratio and
// offset memories need no clearing.
module tridiagonal_system_solver (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [31:0]         sub_diag,
  input  logic signed [31:0]         main_diag,
  input  logic signed [31:0]         super_diag,
  input  logic signed [31:0]         rhs,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         solution,
  output logic [5:0]                 index,
  output logic                       last_of_run,
  output logic                       arith_error,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tds_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import tds_pkg::*;

  state_t state, state_next;

  logic [RC_W-1:0]    row_count;
  logic [ROW_W-1:0]   rows_loaded;
  logic               error_seen;
  logic [ROW_W-1:0]   r;
  logic               is_last;
  logic [ROW_W-1:0]   k;
  logic [ROW_W-1:0]   raddr;
  logic [ROW_W-1:0]   last_idx;
  logic signed [31:0] a, b, c, d;
  logic signed [31:0] den, nr, no, x;
  logic signed [63:0] prod;
  logic signed [63:0] prodq;
  logic signed [31:0] mul_x, mul_y;
  logic signed [31:0] rd_ratio, rd_offset;
  logic signed [31:0] ratio_mem  [MAX_ROWS];
  logic signed [31:0] offset_mem [MAX_ROWS];
  logic               div_start;
  logic signed [31:0] div_num;
  div_res_t           dres;
  sat_t               s_den, s_nr, s_no, s_x;
  logic               in_acc, out_acc;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_ROW_COUNT) ? {{(32-RC_W){1'b0}}, row_count} : 32'd0;
  assign in_stall = state != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = state == S_EOUT;
  assign out_acc  = out_valid && !out_stall;

  assign solution    = rd_ratio;
  assign index       = k;
  assign last_of_run = k == '0;
  assign arith_error = error_seen;

  always_comb begin
    if (row_count < RC_W'(2))
      last_idx = ROW_W'(1);
    else if (row_count > RC_W'(MAX_ROWS))
      last_idx = ROW_W'(MAX_ROWS - 1);
    else
      last_idx = ROW_W'(row_count - RC_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst)
      row_count <= RC_W'(MAX_ROWS);
    else if (psel && penable && pwrite && pready && paddr == REG_ROW_COUNT)
      row_count <= pwdata[RC_W-1:0];
  end

  always_ff @(posedge clk) begin
    rd_ratio  <= ratio_mem[raddr];
    rd_offset <= offset_mem[raddr];
  end

  assign prodq = prod >>> 16;
  assign s_den = sat32({{32{b[31]}}, b} + prodq);
  assign s_nr  = sat32(-{{32{c[31]}}, c});
  assign s_no  = sat32({{32{d[31]}}, d} - prodq);
  assign s_x   = sat32(prodq + {{32{rd_offset[31]}}, rd_offset});

  always_comb begin
    case (state)
      S_BMUL: begin
        mul_x = rd_ratio;
        mul_y = x;
      end
      S_DEN: begin
        mul_x = a;
        mul_y = (r == '0) ? 32'sd0 : rd_offset;
      end
      default: begin
        mul_x = a;
        mul_y = (r == '0) ? 32'sd0 : rd_ratio;
      end
    endcase
  end

  assign div_start = state == S_DIV1_GO || state == S_DIV2_GO;
  assign div_num   = (state == S_DIV1_GO) ? nr : no;

  tds_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .res   (dres)
  );

  always_ff @(posedge clk) begin
    if (rst)
      state <= S_IDLE;
    else
      state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_acc) state_next = S_RD;
      S_RD:        state_next = S_MUL1;
      S_MUL1:      state_next = S_DEN;
      S_DEN:       state_next = S_NO;
      S_NO:        state_next = S_DIV1_GO;
      S_DIV1_GO:   state_next = S_DIV1_WAIT;
      S_DIV1_WAIT: if (dres.done) state_next = S_DIV2_GO;
      S_DIV2_GO:   state_next = S_DIV2_WAIT;
      S_DIV2_WAIT: begin
        if (dres.done) begin
          if (!is_last)
            state_next = S_IDLE;
          else if (r == '0)
            state_next = S_EWT;
          else
            state_next = S_BWT;
        end
      end
      S_BWT:       state_next = S_BMUL;
      S_BMUL:      state_next = S_BADD;
      S_BADD:      state_next = (k == '0) ? S_EWT : S_BWT;
      S_EWT:       state_next = S_EOUT;
      S_EOUT: begin
        if (out_acc)
          state_next = (k == '0) ? S_IDLE : S_EWT;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      error_seen  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            r       <= rows_loaded;
            is_last <= rows_loaded >= last_idx;
            a       <= (rows_loaded == '0) ? 32'sd0 : sub_diag;
            b       <= main_diag;
            c       <= (rows_loaded >= last_idx) ? 32'sd0 : super_diag;
            d       <= rhs;
            raddr   <= rows_loaded - ROW_W'(1);
          end
        end
        S_MUL1: prod <= mul_x * mul_y;
        S_DEN: begin
          den  <= s_den.val;
          nr   <= s_nr.val;
          prod <= mul_x * mul_y;
          if (s_den.err || s_nr.err) error_seen <= 1'b1;
        end
        S_NO: begin
          no <= s_no.val;
          if (s_no.err) error_seen <= 1'b1;
        end
        S_DIV1_WAIT: begin
          if (dres.done) begin
            ratio_mem[r] <= dres.quo;
            if (dres.err) error_seen <= 1'b1;
          end
        end
        S_DIV2_WAIT: begin
          if (dres.done) begin
            offset_mem[r] <= dres.quo;
            if (dres.err) error_seen <= 1'b1;
            if (!is_last) begin
              rows_loaded <= r + ROW_W'(1);
            end else begin
              ratio_mem[r] <= dres.quo;
              x            <= dres.quo;
              if (r == '0) begin
                k     <= r;
                raddr <= r;
              end else begin
                k     <= r - ROW_W'(1);
                raddr <= r - ROW_W'(1);
              end
            end
          end
        end
        S_BMUL: prod <= mul_x * mul_y;
        S_BADD: begin
          x            <= s_x.val;
          ratio_mem[k] <= s_x.val;
          if (s_x.err) error_seen <= 1'b1;
          if (k == '0) begin
            k     <= r;
            raddr <= r;
          end else begin
            k     <= k - ROW_W'(1);
            raddr <= k - ROW_W'(1);
          end
        end
        S_EOUT: begin
          if (out_acc) begin
            if (k == '0) begin
              rows_loaded <= '0;
              error_seen  <= 1'b0;
            end else begin
              k     <= k - ROW_W'(1);
              raddr <= k - ROW_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ tb/sv/tds_checker.sv @@
module tds_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] sub_diag,
  input  logic signed [31:0] main_diag,
  input  logic signed [31:0] super_diag,
  input  logic signed [31:0] rhs,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] solution,
  input  logic [5:0]         index,
  input  logic               last_of_run,
  input  logic               arith_error,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [tds_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 solves_done
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x;
    logic [5:0]         idx;
    logic               last;
    logic               err;
  } unknown_t;

  unknown_t             exp_unknowns[$];
  logic [6:0]           rows_reg;
  logic signed [31:0]   ratio_mem[tds_pkg::MAX_ROWS];
  logic signed [31:0]   offset_mem[tds_pkg::MAX_ROWS];
  int                   rows_swept;
  bit                   fault;

  assign pending = exp_unknowns.size();

  function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) begin
      fault = 1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sh8000_0000) begin
      fault = 1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // floor(x*y / 2^16)
  function automatic logic signed [63:0] qmul(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
    logic signed [63:0] p;
    p = 64'(x) * 64'(y);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] num,
                                               input logic signed [31:0] den);
    logic signed [63:0] n;
    if (den == 0) begin
      fault = 1;
      return (num >= 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    end
    n = 64'(num) <<< 16;
    return clamp(n / 64'(den));
  endfunction

  task automatic sweep_row(input logic signed [31:0] a_in, b, c_in, d);
    int n, r;
    bit at_end;
    logic signed [31:0] a, c, rp, op, den, nr, no, x;
    unknown_t u;
    n = rows_reg;
    if (n < 2) n = 2;
    if (n > tds_pkg::MAX_ROWS) n = tds_pkg::MAX_ROWS;
    r = (rows_swept > tds_pkg::MAX_ROWS - 1) ? tds_pkg::MAX_ROWS - 1 : rows_swept;
    at_end = (r >= n - 1);
    a = (r == 0) ? 32'sd0 : a_in;
    c = at_end ? 32'sd0 : c_in;
    rp = (r == 0) ? 32'sd0 : ratio_mem[r-1];
    op = (r == 0) ? 32'sd0 : offset_mem[r-1];
    den = clamp(64'(b) + qmul(a, rp));
    nr = clamp(-64'(c));
    no = clamp(64'(d) - qmul(a, op));
    ratio_mem[r] = qdiv(nr, den);
    offset_mem[r] = qdiv(no, den);
    if (!at_end) begin
      rows_swept = r + 1;
      return;
    end
    x = offset_mem[r];
    for (int k = r; k >= 0; k--) begin
      if (k != r) x = clamp(qmul(ratio_mem[k], x) + 64'(offset_mem[k]));
      u.x = x;
      u.idx = k[5:0];
      u.last = (k == 0);
      exp_unknowns.push_back(u);
    end
    for (int k = exp_unknowns.size() - r - 1; k < exp_unknowns.size(); k++)
      exp_unknowns[k].err = fault;
    rows_swept = 0;
    fault = 0;
    solves_done++;
  endtask

  task automatic report(input string what, input logic [63:0] got, want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    unknown_t e;
    if (rst) begin
      rows_reg <= 7'd64;
      rows_swept = 0;
      fault = 0;
      exp_unknowns.delete();
      fail_count = 0;
      solves_done = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == tds_pkg::REG_ROW_COUNT)
        rows_reg <= pwdata[6:0];
      if (in_valid && !in_stall) sweep_row(sub_diag, main_diag, super_diag, rhs);
      if (out_valid && !out_stall) begin
        if (exp_unknowns.size() == 0) begin
          report("unexpected transaction, index", 64'(index), 64'd0);
        end else begin
          e = exp_unknowns.pop_front();
          if (solution !== e.x) report("solution", 64'(solution), 64'(e.x));
          if (index !== e.idx) report("index", 64'(index), 64'(e.idx));
          if (last_of_run !== e.last)
            report("last_of_run", 64'(last_of_run), 64'(e.last));
          if (arith_error !== e.err)
            report("arith_error", 64'(arith_error), 64'(e.err));
        end
      end
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic signed [31:0] sub_diag = 0, main_diag = 0, super_diag = 0, rhs = 0;
  logic out_valid, in_stall, last_of_run, arith_error, pready;
  logic signed [31:0] solution;
  logic [5:0] index;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [tds_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 0, prdata;
  int fail_count, pending, solves_done;
  int send_idle = 0, recv_idle = 0;
  bit hold_recv = 0;
  int rows_sent = 0;
  longint cycles = 0;
  int cur_rows;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  tridiagonal_system_solver i_dut (.*);
  tds_checker i_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > 3_000_000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk)
    if (!rst) out_stall <= hold_recv || ($urandom_range(99) < recv_idle);

  task automatic write_rows(input int n);
    while (in_stall || pending != 0) @(negedge clk);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= tds_pkg::REG_ROW_COUNT; pwdata <= n;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    cur_rows = (n < 2) ? 2 : (n > 64 ? 64 : n);
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  function automatic logic [31:0] q_value(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 0;
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  task automatic send_row(input logic [31:0] a, b, c, d);
    do @(negedge clk); while ($urandom_range(99) < send_idle);
    in_valid <= 1; sub_diag <= a; main_diag <= b; super_diag <= c; rhs <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid <= 0;
    rows_sent++;
  endtask

  // diagonally dominant rows, with occasional extremes mixed in
  task automatic send_system(input int n, input int wild);
    logic [31:0] a, b, c, d;
    for (int i = 0; i < n; i++) begin
      a = q_value(4); c = q_value(4); d = q_value(4);
      b = 32'h0008_0000 + $urandom_range(0, 32'h0004_0000);
      if ($urandom_range(1)) b = -b;
      if ($urandom_range(99) < wild) begin
        a = q_value($urandom_range(3)); b = q_value($urandom_range(3));
        c = q_value($urandom_range(3)); d = q_value($urandom_range(3));
      end
      send_row(a, b, c, d);
    end
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    cur_rows = 64;
    // directed: smallest system, extremes, zero pivot, saturation
    write_rows(0);
    send_row(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_row(32'h8000_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_row(32'h0, 32'h0, 32'h0001_0000, 32'h8000_0000);
    send_row(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_row(32'h5555_5555, 32'h8000_0000, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    send_row(32'hAAAA_AAAA, 32'h7FFF_FFFF, 32'h5555_5555, 32'h1);
    drain();
    write_rows(3);
    send_row(0, 32'h0001_0000, 32'h0000_8000, 32'h0003_0000);
    // lower row count mid-solve
    write_rows(2);
    send_row(32'h0000_4000, 32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000);
    drain();
    write_rows(127);
    send_system(64, 5);
    drain();
    write_rows(64);
    // receiver holds off while rows keep arriving
    write_rows(4);
    hold_recv = 1;
    fork
      begin repeat (1200) @(negedge clk); hold_recv = 0; end
      send_system(12, 10);
    join
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 18 : (phase == 1 ? 53 : 0);
      recv_idle = (phase == 0) ? 53 : (phase == 1 ? 18 : 0);
      while (rows_sent < 12 * (phase + 1) + 84) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(2, 16) : $urandom_range(2, 6);
        write_rows(n);
        send_system(cur_rows, 15);
        if ($urandom_range(3) == 0) drain();
      end
      drain();
    end
    drain();
    $display("Sent %0d rows, checked %0d solves across row counts 2..64, with stalls.",
             rows_sent, solves_done);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/tds_pkg.sv
rtl/tds_div.sv
rtl/tridiagonal_system_solver.sv
tb/sv/tds_checker.sv
tb/sv/tb_top.sv
